// File: src/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants of the line crossing counter
// Register map, crossing codes, mark store entry and memory control types.
// ----------------------------------------------------------------------------
package lcc_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_CENTER     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HALF_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_RADIUS     = 3'd4;

   // register reset values
   localparam logic [9:0]  RST_LINE_CENTER     = 10'd120;
   localparam logic [6:0]  RST_BAND_HALF_WIDTH = 7'd20;
   localparam logic [10:0] RST_LINE_LENGTH     = 11'd640;
   localparam logic [6:0]  RST_HOLD_TIME       = 7'd10;
   localparam logic [7:0]  RST_MARK_RADIUS     = 8'd40;

   // result codes
   typedef enum logic [1:0] {
      CROSS_NONE = 2'd0,
      CROSS_IN   = 2'd1,
      CROSS_OUT  = 2'd2
   } crossing_type;

   // configuration registers as seen by the sequencer
   typedef struct packed {
      logic [9:0]  line_center;
      logic [6:0]  band_half_width;
      logic [10:0] line_length;
      logic [6:0]  hold_time;
      logic [7:0]  mark_radius;
   } cfg_type;

   // one line position in the mark store
   typedef struct packed {
      logic       valid;
      logic [6:0] age;
   } mark_type;

   // mark store access control
   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      mark_type wr_data;
   } mem_ctl_type;

endpackage

// File: src/lcc_req_if.sv
// ----------------------------------------------------------------------------
// lcc_req_if: request channel of the line crossing counter
// Valid/ready handshake carrying one object centroid and heading point.
// ----------------------------------------------------------------------------
interface lcc_req_if;
   logic              valid;
   logic              ready;
   logic [9:0]        cross_coord;
   logic [9:0]        along_coord;
   logic signed [11:0] heading_coord;

   modport source (output valid, output cross_coord, output along_coord,
                   output heading_coord, input ready);
   modport sink   (input valid, input cross_coord, input along_coord,
                   input heading_coord, output ready);
endinterface

// File: src/lcc_rsp_if.sv
// ----------------------------------------------------------------------------
// lcc_rsp_if: response channel of the line crossing counter
// Valid/ready handshake carrying the crossing code and the running totals.
// ----------------------------------------------------------------------------
interface lcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  crossing;
   logic [15:0] in_total;
   logic [15:0] out_total;

   modport source (output valid, output crossing, output in_total,
                   output out_total, input ready);
   modport sink   (input valid, input crossing, input in_total,
                   input out_total, output ready);
endinterface

// File: src/line_crossing_counter.sv
// ----------------------------------------------------------------------------
// line_crossing_counter: counts objects crossing a detection line
// Top level: configuration registers, mark store, sequencer, totals and
// the response register.
// ----------------------------------------------------------------------------
// Each request sets off an aging sweep over the min(line_length, LINE_POSITIONS)
// positions in use of the mark store (one position a cycle through its read
// port and its write port).
// Throughput: one request at a time; the next one is taken in the cycle after
// the response loads into the output register.
// Reset: synchronous; then a clearing pass over all LINE_POSITIONS entries
// with req_bus.ready low. Configuration writes are taken at any time.
module line_crossing_counter import lcc_pkg::*; #(
   parameter int LINE_POSITIONS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   lcc_req_if.sink               req_bus,
   lcc_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(LINE_POSITIONS);
   localparam int LEN_W  = $clog2(LINE_POSITIONS + 1);

   cfg_type           cfg_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   crossing_type      crossing_ff;
   logic [15:0]       in_cnt_ff, out_cnt_ff;

   logic              done_valid;
   crossing_type      done_code;
   logic              out_free;
   logic              load;
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [ADDR_W-1:0] mem_wr_addr;
   mark_type          mem_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_center     <= RST_LINE_CENTER;
         cfg_ff.band_half_width <= RST_BAND_HALF_WIDTH;
         cfg_ff.line_length     <= RST_LINE_LENGTH;
         cfg_ff.hold_time       <= RST_HOLD_TIME;
         cfg_ff.mark_radius     <= RST_MARK_RADIUS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_CENTER:     cfg_ff.line_center     <= csr_wdata[9:0];
            CSR_BAND_HALF_WIDTH: cfg_ff.band_half_width <= csr_wdata[6:0];
            CSR_LINE_LENGTH:     cfg_ff.line_length     <= csr_wdata[10:0];
            CSR_HOLD_TIME:       cfg_ff.hold_time       <= csr_wdata[6:0];
            CSR_MARK_RADIUS:     cfg_ff.mark_radius     <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   lcc_mark_mem #(
      .DEPTH  (LINE_POSITIONS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .rd_data (mem_rd_data)
   );

   lcc_ctrl #(
      .DEPTH  (LINE_POSITIONS),
      .ADDR_W (ADDR_W),
      .LEN_W  (LEN_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_cross   (req_bus.cross_coord),
      .req_along   (req_bus.along_coord),
      .req_heading (req_bus.heading_coord),
      .done_valid  (done_valid),
      .done_code   (done_code),
      .out_free    (out_free),
      .mem_ctl     (mem_ctl),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_data (mem_rd_data)
   );

   // response register, free when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign load     = done_valid && out_free;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // running totals move together with the response they belong to
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load && (done_code == CROSS_IN)) begin
            in_cnt_ff <= in_cnt_ff + 16'd1;
         end
         if (load && (done_code == CROSS_OUT)) begin
            out_cnt_ff <= out_cnt_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         crossing_ff <= done_code;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.crossing  = crossing_ff;
   assign rsp_bus.in_total  = in_cnt_ff;
   assign rsp_bus.out_total = out_cnt_ff;

endmodule

// File: src/lcc_mark_mem.sv
// ----------------------------------------------------------------------------
// lcc_mark_mem: mark store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcc_mark_mem import lcc_pkg::*; #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] wr_addr,
   output mark_type          rd_data
);

   mark_type mem_ff [DEPTH];
   mark_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= ctl.wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lcc_ctrl.sv
// ----------------------------------------------------------------------------
// lcc_ctrl: sequencer of the line crossing counter
// Clears the mark store after reset, then per request ages every position
// in use, looks up the centroid position of a hit and marks the run around it when unmarked.
// ----------------------------------------------------------------------------
module lcc_ctrl import lcc_pkg::*; #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int LEN_W  = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   // request side
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_cross,
   input  logic [9:0]         req_along,
   input  logic signed [11:0] req_heading,
   // finished result
   output logic               done_valid,
   output crossing_type       done_code,
   input  logic               out_free,
   // mark store
   output mem_ctl_type        mem_ctl,
   output logic [ADDR_W-1:0]  mem_rd_addr,
   output logic [ADDR_W-1:0]  mem_wr_addr,
   input  mark_type           mem_rd_data
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_AGE   = 7'b0000100,
      ST_LOOK  = 7'b0001000,
      ST_CHECK = 7'b0010000,
      ST_MARK  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   localparam logic [LEN_W-1:0] LAST_POS = LEN_W'(DEPTH - 1);

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  wb_addr_ff, wb_addr_in;
   logic [LEN_W-1:0]   start_ff, start_in;
   logic [LEN_W-1:0]   end_ff, end_in;
   logic [9:0]         cross_ff, cross_in;
   logic [9:0]         along_ff, along_in;
   logic signed [11:0] heading_ff, heading_in;
   crossing_type       code_ff, code_in;

   logic [LEN_W-1:0]   len;
   logic               in_band;
   logic               hit;
   logic               sweep_more;
   mark_type           aged;

   // positions in use
   always_comb begin
      if (int'(cfg.line_length) > DEPTH) begin
         len = LEN_W'(DEPTH);
      end else begin
         len = LEN_W'(cfg.line_length);
      end
   end

   // strict band test around the line
   assign in_band = (({1'b0, cross_ff} + 11'(cfg.band_half_width)) > {1'b0, cfg.line_center})
                 && ({1'b0, cross_ff} < ({1'b0, cfg.line_center} + 11'(cfg.band_half_width)));

   // detection candidate: in band, on the line and a nonempty run
   assign hit = in_band && (int'(along_ff) < int'(len)) && (cfg.mark_radius != 8'd0);

   assign sweep_more = (cnt_ff < len);

   // aging of one entry: bump the age, drop the mark past the hold time
   always_comb begin
      logic [7:0] sum;
      sum = {1'b0, mem_rd_data.age} + 8'd1;
      if (sum > {1'b0, cfg.hold_time}) begin
         aged = '0;
      end else begin
         aged = '{valid: 1'b1, age: sum[6:0]};
      end
   end

   // next state
   always_comb begin
      int run_start;
      int run_end;
      run_start = int'(along_ff) - int'(cfg.mark_radius);
      run_end   = int'(along_ff) + int'(cfg.mark_radius);
      if (run_start < 0) begin
         run_start = 0;
      end
      if (run_end > int'(len)) begin
         run_end = int'(len);
      end

      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      wb_addr_in  = wb_addr_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      cross_in    = cross_ff;
      along_in    = along_ff;
      heading_in  = heading_ff;
      code_in     = code_ff;
      req_ready   = 1'b0;
      done_valid  = 1'b0;
      mem_ctl     = '0;
      mem_rd_addr = cnt_ff[ADDR_W-1:0];
      mem_wr_addr = cnt_ff[ADDR_W-1:0];

      unique case (state_ff)
         // zero the store, one entry a cycle
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            cnt_in        = cnt_ff + LEN_W'(1);
            if (cnt_ff == LAST_POS) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cross_in   = req_cross;
               along_in   = req_along;
               heading_in = req_heading;
               cnt_in     = '0;
               pend_in    = 1'b0;
               state_in   = ST_AGE;
            end
         end
         // read entry n while writing back entry n-1
         ST_AGE: begin
            pend_in = sweep_more;
            if (sweep_more) begin
               mem_ctl.rd_en = 1'b1;
               cnt_in        = cnt_ff + LEN_W'(1);
               wb_addr_in    = cnt_ff[ADDR_W-1:0];
            end
            if (pend_ff && mem_rd_data.valid) begin
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_data = aged;
               mem_wr_addr     = wb_addr_ff;
            end
            if (!pend_ff && !sweep_more) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            start_in = LEN_W'(run_start);
            end_in   = LEN_W'(run_end);
            if (hit) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = ADDR_W'(along_ff);
               state_in      = ST_CHECK;
            end else begin
               code_in  = CROSS_NONE;
               state_in = ST_DONE;
            end
         end
         // centroid position already marked: no detection
         ST_CHECK: begin
            if (mem_rd_data.valid) begin
               code_in  = CROSS_NONE;
               state_in = ST_DONE;
            end else begin
               cnt_in   = start_ff;
               code_in  = ($signed(heading_ff) > $signed({2'b00, cross_ff})) ?
                          CROSS_IN : CROSS_OUT;
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_data = '{valid: 1'b1, age: 7'd0};
            cnt_in          = cnt_ff + LEN_W'(1);
            if ((cnt_ff + LEN_W'(1)) == end_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            done_valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   // request and working registers
   always_ff @(posedge clock) begin
      wb_addr_ff <= wb_addr_in;
      start_ff   <= start_in;
      end_ff     <= end_in;
      cross_ff   <= cross_in;
      along_ff   <= along_in;
      heading_ff <= heading_in;
      code_ff    <= code_in;
   end

   assign done_code = code_ff;

endmodule

// File: src/lcc_checker.sv
// ----------------------------------------------------------------------------
// lcc_checker: port checks of the line crossing counter
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module lcc_checker import lcc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  crossing,
   input logic [15:0] in_total,
   input logic [15:0] out_total
);

   // clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after a request was taken");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(crossing)
         && $stable(in_total) && $stable(out_total)))
      else $error("response changed while stalled");

   // inward total steps by one only with a new inward response
   a_in_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(in_total) |-> (rsp_valid && (crossing == CROSS_IN)
         && (in_total == $past(in_total) + 16'd1)))
      else $error("inward total moved without an inward crossing");

   // outward total steps by one only with a new outward response
   a_out_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(out_total) |-> (rsp_valid && (crossing == CROSS_OUT)
         && (out_total == $past(out_total) + 16'd1)))
      else $error("outward total moved without an outward crossing");

endmodule

bind line_crossing_counter lcc_checker u_lcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .crossing  (rsp_bus.crossing),
   .in_total  (rsp_bus.in_total),
   .out_total (rsp_bus.out_total)
);

// File: bench/lcc_crossing_monitor.sv
// ----------------------------------------------------------------------------
// lcc_crossing_monitor: crossing predictor and response comparator
// Follows register writes and accepted requests, keeps its own copy of the
// mark store and the totals, and compares each response with the oldest
// predicted tally. Failures and the number of outstanding tallies go to the
// testbench top.
// ----------------------------------------------------------------------------
module lcc_crossing_monitor import lcc_pkg::*; #(
   parameter int LINE_POSITIONS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   lcc_req_if                    req_bus,
   lcc_rsp_if                    rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      crossing_type crossing;
      logic [15:0]  in_total;
      logic [15:0]  out_total;
   } tally_type;

   // shadow registers
   logic [9:0]  line_center;
   logic [6:0]  band_half_width;
   logic [10:0] line_length;
   logic [6:0]  hold_time;
   logic [7:0]  mark_radius;

   // shadow mark store and totals
   bit          line_marked [LINE_POSITIONS];
   int          mark_age [LINE_POSITIONS];
   logic [15:0] in_count;
   logic [15:0] out_count;

   tally_type   pending_tallies [$];
   int          failures = 0;
   int          outstanding = 0;

   assign fail_count    = failures;
   assign pending_count = outstanding;

   // age the marks, mark a new run if the centroid is in the band, count it
   function automatic tally_type count_crossing(input logic [9:0] cross_pos,
                                                input logic [9:0] along_pos,
                                                input logic signed [11:0] heading_pos);
      int        span;
      int        radius;
      int        centroid;
      int        along;
      int        next_age;
      bit        marked;
      tally_type tally;
      span     = (line_length > LINE_POSITIONS) ? LINE_POSITIONS : int'(line_length);
      radius   = int'(mark_radius);
      centroid = int'(cross_pos);
      along    = int'(along_pos);
      marked   = 1'b0;

      // positions beyond the length in use are left alone
      for (int p = 0; p < span; p++) begin
         if (line_marked[p]) begin
            next_age = mark_age[p] + 1;
            if (next_age > int'(hold_time)) begin
               line_marked[p] = 1'b0;
               mark_age[p]    = 0;
            end else begin
               mark_age[p] = next_age;
            end
         end
      end

      // strict band, along position must lie on the line
      if (int'(line_center) - int'(band_half_width) < centroid &&
          centroid < int'(line_center) + int'(band_half_width) && along < span) begin
         if (!line_marked[along]) begin
            for (int p = along - radius; p < along + radius; p++) begin
               if (p >= 0 && p < span) begin
                  line_marked[p] = 1'b1;
                  mark_age[p]    = 0;
                  marked         = 1'b1;
               end
            end
         end
      end

      tally.crossing = CROSS_NONE;
      if (marked) begin
         // heading level with the centroid counts as outward
         if (int'(heading_pos) - centroid > 0) begin
            tally.crossing = CROSS_IN;
            in_count       = in_count + 16'd1;
         end else begin
            tally.crossing = CROSS_OUT;
            out_count      = out_count + 16'd1;
         end
      end
      tally.in_total  = in_count;
      tally.out_total = out_count;
      return tally;
   endfunction

   // register writes, response compare, request prediction
   always @(posedge clock) begin
      tally_type want;
      if (reset) begin
         line_center     = RST_LINE_CENTER;
         band_half_width = RST_BAND_HALF_WIDTH;
         line_length     = RST_LINE_LENGTH;
         hold_time       = RST_HOLD_TIME;
         mark_radius     = RST_MARK_RADIUS;
         for (int p = 0; p < LINE_POSITIONS; p++) begin
            line_marked[p] = 1'b0;
            mark_age[p]    = 0;
         end
         in_count  = '0;
         out_count = '0;
         pending_tallies.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LINE_CENTER:     line_center     = csr_wdata[9:0];
               CSR_BAND_HALF_WIDTH: band_half_width = csr_wdata[6:0];
               CSR_LINE_LENGTH:     line_length     = csr_wdata[10:0];
               CSR_HOLD_TIME:       hold_time       = csr_wdata[6:0];
               CSR_MARK_RADIUS:     mark_radius     = csr_wdata[7:0];
               default: ;
            endcase
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_tallies.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: unexpected response: crossing %0d in_total %0d out_total %0d",
                           $time, rsp_bus.crossing, rsp_bus.in_total, rsp_bus.out_total);
            end else begin
               want = pending_tallies.pop_front();
               if (rsp_bus.crossing !== want.crossing || rsp_bus.in_total !== want.in_total ||
                   rsp_bus.out_total !== want.out_total) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("%0t: mismatch: crossing %0d/%0d in_total %0d/%0d out_total %0d/%0d (exp/got)",
                              $time, want.crossing, rsp_bus.crossing, want.in_total,
                              rsp_bus.in_total, want.out_total, rsp_bus.out_total);
               end
            end
         end

         if (req_bus.valid && req_bus.ready)
            pending_tallies.push_back(count_crossing(req_bus.cross_coord, req_bus.along_coord,
                                                     req_bus.heading_coord));
      end
      outstanding = pending_tallies.size();
   end

endmodule

// File: bench/line_crossing_counter_tb.sv
// ----------------------------------------------------------------------------
// line_crossing_counter_tb: testbench top of the line crossing counter
// Drives a directed set of requests over the register extremes and corner
// cases, then random phases of mostly in-band requests with bursty requests
// and a stalling response side. The monitor predicts and compares; this
// module makes stimulus, runs the watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module line_crossing_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lcc_pkg::*;

   localparam int LINE_POSITIONS  = 1024;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int IDLE_LIMIT      = 20000;
   localparam int DRAIN_CYCLES    = 2000;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum int {SINK_OPEN, SINK_PATTERN, SINK_RANDOM} sink_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;

   // register values as last written, for shaping requests
   int                    cfg_center;
   int                    cfg_band;
   int                    cfg_length;

   int                    idle_cycles = 0;
   sink_mode_type         sink_mode = SINK_OPEN;
   int                    sink_left = 0;
   logic [31:0]           sink_pattern = '1;

   lcc_req_if req_bus ();
   lcc_rsp_if rsp_bus ();

   line_crossing_counter #(.LINE_POSITIONS(LINE_POSITIONS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lcc_crossing_monitor #(.LINE_POSITIONS(LINE_POSITIONS)) u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("line_crossing_counter_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: open, rotating stall pattern, or random stalls
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode    = sink_mode_type'($urandom_range(2, 0));
         sink_left    = $urandom_range(400, 40);
         sink_pattern = $urandom;
      end else begin
         sink_left = sink_left - 1;
      end
      case (sink_mode)
         SINK_OPEN: rsp_bus.ready <= 1'b1;
         SINK_PATTERN: begin
            rsp_bus.ready <= sink_pattern[0];
            sink_pattern = {sink_pattern[0], sink_pattern[31:1]};
         end
         default: rsp_bus.ready <= ($urandom_range(2, 0) != 0);
      endcase
   end

   // one register write, called and returning at a falling edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_LINE_CENTER:     cfg_center = value & 'h3FF;
         CSR_BAND_HALF_WIDTH: cfg_band   = value & 'h7F;
         CSR_LINE_LENGTH:     cfg_length = value & 'h7FF;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(input int center, input int band, input int length,
                            input int hold, input int radius);
      write_reg(CSR_LINE_CENTER, center);
      write_reg(CSR_BAND_HALF_WIDTH, band);
      write_reg(CSR_LINE_LENGTH, length);
      write_reg(CSR_HOLD_TIME, hold);
      write_reg(CSR_MARK_RADIUS, radius);
      csr_we <= 1'b0;
   endtask

   // hold one request until accepted; valid stays high on return
   task automatic send(input logic [9:0] cross_pos, input logic [9:0] along_pos,
                       input logic signed [11:0] heading_pos);
      req_bus.valid         <= 1'b1;
      req_bus.cross_coord   <= cross_pos;
      req_bus.along_coord   <= along_pos;
      req_bus.heading_coord <= heading_pos;
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending until every response is back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // mostly in-band requests on the line, the rest anywhere
   task automatic make_request(output logic [9:0] cross_pos, output logic [9:0] along_pos,
                               output logic signed [11:0] heading_pos);
      int lo;
      int hi;
      int span;
      bit in_band;
      in_band = ($urandom_range(3, 0) != 0);
      lo   = cfg_center - cfg_band + 1;
      hi   = cfg_center + cfg_band - 1;
      if (lo < 0) lo = 0;
      if (hi > 1023) hi = 1023;
      span = (cfg_length > LINE_POSITIONS) ? LINE_POSITIONS : cfg_length;
      if (in_band && lo <= hi) cross_pos = 10'($urandom_range(hi, lo));
      else cross_pos = 10'($urandom);
      if (in_band && span > 0) along_pos = 10'($urandom_range(span - 1, 0));
      else along_pos = 10'($urandom);
      case ($urandom_range(3, 0))
         0: heading_pos = 12'($urandom);
         1: heading_pos = 12'(cross_pos);
         2: heading_pos = 12'(int'(cross_pos) + int'($urandom_range(16, 1)));
         default: heading_pos = 12'(int'(cross_pos) - int'($urandom_range(16, 1)));
      endcase
   endtask

   // an extreme now and then, otherwise anywhere in range
   function automatic int pick_setting(input int low, input int high);
      if ($urandom_range(3, 0) == 0) return ($urandom_range(1, 0) == 0) ? low : high;
      return $urandom_range(high, low);
   endfunction

   initial begin
      logic [9:0]         cross_pos;
      logic [9:0]         along_pos;
      logic signed [11:0] heading_pos;
      int                 sent;
      int                 burst;
      int                 gap;

      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_LINE_CENTER;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.cross_coord   = '0;
      req_bus.along_coord   = '0;
      req_bus.heading_coord = '0;
      rsp_bus.ready         = 1'b0;
      cfg_center            = RST_LINE_CENTER;
      cfg_band              = RST_BAND_HALF_WIDTH;
      cfg_length            = RST_LINE_LENGTH;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: band edges, clipping at both ends, heading extremes
      send(10'd120, 10'd300, 12'sd200);    // inward
      send(10'd121, 10'd300, 12'sd100);    // position already marked
      send(10'd110, 10'd0, 12'sd110);      // heading level with centroid, run clipped at 0
      send(10'd130, 10'd639, -12'sd2048);  // run clipped at line end
      send(10'd100, 10'd500, 12'sd300);    // on lower band edge
      send(10'd140, 10'd500, 12'sd300);    // on upper band edge
      send(10'd0, 10'd1023, 12'sd0);
      send(10'd1023, 10'd1023, -12'sd1);
      send(10'd120, 10'd640, 12'sd500);    // along position just off the line

      // length beyond the store, zero hold, band of 80 and widest radius
      wait_idle();
      configure(0, 80, 2047, 0, 255);
      send(10'd1, 10'd1023, 12'sd2047);
      send(10'd79, 10'd1023, 12'sd0);      // mark expired after one step
      send(10'd80, 10'd5, 12'sd0);

      // zero length: nothing ages, nothing detected
      wait_idle();
      configure(1023, 80, 0, 100, 255);
      send(10'd1000, 10'd0, 12'sd1023);

      // one position, zero radius, then writes to unused indexes
      wait_idle();
      configure(512, 1, 1, 100, 0);
      send(10'd512, 10'd0, 12'sd600);
      wait_idle();
      write_reg(CSR_SPARE_LO, 'h7FF);
      write_reg(CSR_SPARE_HI, 0);
      write_reg(CSR_MARK_RADIUS, 1);
      csr_we <= 1'b0;
      send(10'd512, 10'd0, 12'sd600);
      send(10'd512, 10'd0, 12'sd100);

      // full length, zero band
      wait_idle();
      configure(1023, 0, 1024, 0, 255);
      send(10'd1023, 10'd1023, 12'sd0);

      // random phases, each with its own settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         configure(pick_setting(0, 1023), pick_setting(0, 80),
                   ($urandom_range(9, 0) == 0) ? 2047 : pick_setting(0, 1024),
                   pick_setting(0, 100), pick_setting(0, 255));
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(8, 1);
            for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
               make_request(cross_pos, along_pos, heading_pos);
               send(cross_pos, along_pos, heading_pos);
               sent++;
            end
            if ($urandom_range(24, 0) == 0) begin
               wait_idle();
            end else begin
               gap = ($urandom_range(3, 0) == 0) ? $urandom_range(1600, 0)
                                                 : $urandom_range(12, 0);
               if (gap > 0) begin
                  req_bus.valid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
            end
         end
      end

      // drain, then allow for stray responses
      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("line_crossing_counter_tb OK");
      else
         $display("line_crossing_counter_tb NOT OK");
      $finish;
   end

endmodule
